>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define LDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define LDS_ASSERT_NEXT(label, ante, cons, msg) \
  `LDS_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> rtl/core/lds_pkg.sv
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types and constants of the LOOK disk scheduler.
// ----------------------------------------------------------------------------
package lds_pkg;

  localparam int TRACK_W = 16;
  localparam int SEEK_W  = 17;
  localparam int SUM_W   = 18;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [TRACK_W-1:0] track;
    logic [TRACK_W-1:0] head_track;
    logic               move_up;
  } in_item_t;

  typedef struct packed {
    logic [TRACK_W-1:0] served_track;
    logic               served_valid;
    logic [SEEK_W-1:0]  seek_total;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_SCAN,
    ST_UP,
    ST_DOWN
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic ins;          // sorted insert of the input track
    logic start;        // latch head, clear sum and pointer
    logic scan_step;    // advance the search pointer
    logic scan_hit;     // remember the pointer as the split index
    logic ptr_to_idx;   // rewind the pointer to the split index
    logic serve;        // serve one track and load the output register
    logic sel_down;     // read below the pointer and walk downward
    logic last;         // mark the served result as final
    logic emit_empty;   // load the empty-run result
    logic clear_count;  // drop all stored requests
  } lds_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic scan_done;
    logic up_left;
    logic down_left;
    logic up_last;
    logic down_last;
    logic idx_zero;
    logic idx_at_count;
    logic out_free;
  } lds_sts_t;

endpackage

>>> rtl/core/lds_ctrl.sv
// ----------------------------------------------------------------------------
// lds_ctrl
// Sequencer: load, empty run, split search, first sweep, reversal, second sweep.
// ----------------------------------------------------------------------------
module lds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              req_type,
  input  logic              move_up,
  output logic              in_stall,
  output lds_pkg::lds_cmd_t cmd,
  input  lds_pkg::lds_sts_t sts
);
  import lds_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       up_first_r, up_first_nxt;
  logic       second_r, second_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      up_first_r <= 1'b0;
      second_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      up_first_r <= up_first_nxt;
      second_r   <= second_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    up_first_nxt = up_first_r;
    second_nxt   = second_r;
    cmd          = '0;
    in_stall     = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_LOAD) begin
            cmd.ins = 1'b1;
          end else begin
            cmd.start    = 1'b1;
            up_first_nxt = move_up;
            second_nxt   = 1'b0;
            state_nxt    = sts.count_zero ? ST_EMPTY : ST_SCAN;
          end
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty  = 1'b1;
          cmd.clear_count = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          cmd.scan_hit = 1'b1;
          state_nxt    = up_first_r ? ST_UP : ST_DOWN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_UP: begin
        if (sts.up_left) begin
          if (sts.out_free) begin
            cmd.serve = 1'b1;
            cmd.last  = sts.up_last && (second_r || sts.idx_zero);
            if (cmd.last) begin
              cmd.clear_count = 1'b1;
              state_nxt       = ST_IDLE;
            end
          end
        end else begin
          // upward part done or empty, reverse
          cmd.ptr_to_idx = 1'b1;
          second_nxt     = 1'b1;
          state_nxt      = ST_DOWN;
        end
      end
      ST_DOWN: begin
        cmd.sel_down = 1'b1;
        if (sts.down_left) begin
          if (sts.out_free) begin
            cmd.serve = 1'b1;
            cmd.last  = sts.down_last && (second_r || sts.idx_at_count);
            if (cmd.last) begin
              cmd.clear_count = 1'b1;
              state_nxt       = ST_IDLE;
            end
          end
        end else begin
          // downward part done or empty, reverse
          cmd.ptr_to_idx = 1'b1;
          second_nxt     = 1'b1;
          state_nxt      = ST_UP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/lds_datapath.sv
// ----------------------------------------------------------------------------
// lds_datapath
// Sorted shifting request store, sweep pointer, seek sum, output register.
// ----------------------------------------------------------------------------
module lds_datapath #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lds_pkg::lds_cmd_t cmd,
  output lds_pkg::lds_sts_t sts,
  input  lds_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lds_pkg::out_item_t out_data
);
  import lds_pkg::*;

  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQUESTS);

  logic [TRACK_W-1:0]    store_r [MAX_REQUESTS];
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         ptr_r, ptr_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [TRACK_W-1:0]    head_r, head_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;
  logic [MAX_REQUESTS-1:0] gt;
  logic                  do_ins;
  logic [CW-1:0]         rd_ptr;
  logic [IW-1:0]         rd_addr;
  logic [TRACK_W-1:0]    rd_data;
  logic [TRACK_W-1:0]    step_dist;
  logic [SUM_W-1:0]      sum_add;

  // entries above the new track, per slot
  always_comb begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      gt[i] = (CW'(i) < count_r) && (store_r[i] > in_data.track);
    end
  end

  assign do_ins = cmd.ins && (count_r != MAX_CNT);

  // sorted insert: larger entries shift up one slot
  for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_slot
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (do_ins && (gt[0] || count_r == '0)) begin
          store_r[0] <= in_data.track;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (do_ins) begin
          if (gt[g-1]) begin
            store_r[g] <= store_r[g-1];
          end else if (gt[g] || CW'(g) == count_r) begin
            store_r[g] <= in_data.track;
          end
        end
      end
    end
  end

  // single read port, below the pointer when walking down
  assign rd_ptr  = cmd.sel_down ? (ptr_r - 1'b1) : ptr_r;
  assign rd_addr = rd_ptr[IW-1:0];
  assign rd_data = store_r[rd_addr];

  // head movement for this step
  assign step_dist = (rd_data >= head_r) ? (rd_data - head_r) : (head_r - rd_data);
  assign sum_add   = sum_r + SUM_W'(step_dist);

  // next values
  always_comb begin
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    sum_nxt       = sum_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (do_ins) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.start) begin
      head_nxt = in_data.head_track;
      sum_nxt  = '0;
      ptr_nxt  = '0;
    end
    if (cmd.scan_step) begin
      ptr_nxt = ptr_r + 1'b1;
    end
    if (cmd.scan_hit) begin
      idx_nxt = ptr_r;
    end
    if (cmd.ptr_to_idx) begin
      ptr_nxt = idx_r;
    end
    if (cmd.serve) begin
      ptr_nxt                = cmd.sel_down ? (ptr_r - 1'b1) : (ptr_r + 1'b1);
      head_nxt               = rd_data;
      sum_nxt                = sum_add;
      out_nxt.served_track   = rd_data;
      out_nxt.served_valid   = 1'b1;
      out_nxt.seek_total     = sum_add[SEEK_W-1:0];
      out_nxt.last_of_run    = cmd.last;
      out_valid_nxt          = 1'b1;
    end
    if (cmd.emit_empty) begin
      out_nxt.served_track = '0;
      out_nxt.served_valid = 1'b0;
      out_nxt.seek_total   = '0;
      out_nxt.last_of_run  = 1'b1;
      out_valid_nxt        = 1'b1;
    end
    if (cmd.clear_count) begin
      count_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_r      <= '0;
      sum_r       <= '0;
      ptr_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      sum_r       <= sum_nxt;
      ptr_r       <= ptr_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // status
  always_comb begin
    sts.count_zero   = (count_r == '0);
    sts.scan_done    = (ptr_r == count_r) || (rd_data >= head_r);
    sts.up_left      = (ptr_r != count_r);
    sts.down_left    = (ptr_r != '0);
    sts.up_last      = (CW'(ptr_r + 1'b1) == count_r);
    sts.down_last    = (ptr_r == CW'(1));
    sts.idx_zero     = (idx_r == '0);
    sts.idx_at_count = (idx_r == count_r);
    sts.out_free     = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/look_disk_scheduler_unit.sv
// Load: a request is taken while the unit is idle and inserted in sorted place in
// the shifting store, unless the store is full. Start: the split search steps past
// every stored request below the head, then one result per cycle from the single
// store read port while the output is not stalled, with a reversal step between the
// sweeps unless the first sweep serves every request.
// Synchronous active-low reset empties the store and clears head and sum.
// ----------------------------------------------------------------------------
// look_disk_scheduler_unit
// LOOK disk scheduler: sorted request store served in at most two sweeps.
// ----------------------------------------------------------------------------
module look_disk_scheduler_unit #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lds_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lds_pkg::out_item_t out_data
);
  import lds_pkg::*;

  lds_cmd_t cmd;
  lds_sts_t sts;

  // sequencer
  lds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_data.req_type),
    .move_up  (in_data.move_up),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // store and arithmetic
  lds_datapath #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/lds_checker.sv
// ----------------------------------------------------------------------------
// lds_checker
// Port-level checks on the scheduler's transfers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lds_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input lds_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input lds_pkg::out_item_t out_data
);
  import lds_pkg::*;

  // a stalled result stays offered
  `LDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

  // a stalled result keeps its payload
  `LDS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "result changed under stall")

  // an empty-run result is the single final one with zero fields
  `LDS_ASSERT(a_empty_form, out_valid && !out_data.served_valid |-> out_data.last_of_run && out_data.seek_total == '0 && out_data.served_track == '0, "malformed empty result")

  // a start transfer blocks input right after it is taken
  `LDS_ASSERT_NEXT(a_start_busy, in_valid && !in_stall && in_data.req_type == REQ_START, in_stall, "input open right after start")

endmodule

bind look_disk_scheduler_unit lds_checker u_lds_checker (.*);
